@@ rtl/assert_macros.svh @@
// Assertion helpers for the memory map decoder. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bmm_pkg.sv @@
package bmm_pkg;

  localparam int RAM_BYTES    = 65536;
  localparam int BASIC_BYTES  = 8192;
  localparam int KERNAL_BYTES = 8192;
  localparam int CHAR_BYTES   = 4096;

  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int CMD_W  = 3;
  localparam int SEL_W  = 2;

  // Every store is split into an even and an odd bank, so that the two bytes
  // of a word always land in different banks.
  localparam int RAM_BANK_DEPTH   = RAM_BYTES / 2;
  localparam int BASIC_BANK_DEPTH = BASIC_BYTES / 2;
  localparam int KERNAL_BANK_DEPTH = KERNAL_BYTES / 2;
  localparam int CHAR_BANK_DEPTH  = CHAR_BYTES / 2;

  localparam int RAM_IDX_W  = $clog2(RAM_BANK_DEPTH);
  localparam int ROM_IDX_W  = $clog2(BASIC_BANK_DEPTH);
  localparam int CHAR_IDX_W = $clog2(CHAR_BANK_DEPTH);

  localparam logic [CMD_W-1:0] CMD_READ_BYTE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_BYTE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ_WORD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE_WORD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOAD_ROM   = 3'd4;

  localparam logic [SEL_W-1:0] ROM_BASIC  = 2'd0;
  localparam logic [SEL_W-1:0] ROM_KERNAL = 2'd1;
  localparam logic [SEL_W-1:0] ROM_CHAR   = 2'd2;

  // Index of each ROM in the per-bank write enable vectors.
  localparam int ROM_IDX_BASIC  = 0;
  localparam int ROM_IDX_KERNAL = 1;
  localparam int ROM_IDX_CHAR   = 2;
  localparam int ROM_COUNT      = 3;

  localparam logic [ADDR_W-1:0] BASIC_BASE  = 16'hA000;
  localparam logic [ADDR_W-1:0] KERNAL_BASE = 16'hE000;
  localparam logic [ADDR_W-1:0] CHAR_BASE   = 16'hD000;
  localparam logic [ADDR_W-1:0] PORT_ADDR   = 16'h0001;

  localparam int BASIC_REGION_W = $clog2(BASIC_BYTES);
  localparam int KERNAL_REGION_W = $clog2(KERNAL_BYTES);
  localparam int CHAR_REGION_W = $clog2(CHAR_BYTES);

  localparam int PORT_BASIC_BIT  = 0;
  localparam int PORT_KERNAL_BIT = 1;
  localparam int PORT_CHAR_BIT   = 2;

  // Reset value of RAM bytes 0 and 1, the second being the I/O port.
  localparam logic [BYTE_W-1:0] RAM_LOW_RESET = 8'h07;

  typedef logic [1:0] src_t;
  localparam src_t SRC_RAM    = 2'd0;
  localparam src_t SRC_BASIC  = 2'd1;
  localparam src_t SRC_KERNAL = 2'd2;
  localparam src_t SRC_CHAR   = 2'd3;

  typedef logic [1:0] res_kind_t;
  localparam res_kind_t RES_NONE = 2'd0;
  localparam res_kind_t RES_BYTE = 2'd1;
  localparam res_kind_t RES_WORD = 2'd2;

  typedef struct packed {
    src_t      src_even;
    src_t      src_odd;
    logic      swap;
    res_kind_t kind;
  } rd_ctl_t;

  typedef struct packed {
    logic [RAM_IDX_W-1:0] ram_even_idx;
    logic [RAM_IDX_W-1:0] ram_odd_idx;
    logic                 ram_even_we;
    logic                 ram_odd_we;
    logic [ROM_IDX_W-1:0] rom_even_idx;
    logic [ROM_IDX_W-1:0] rom_odd_idx;
    logic [ROM_COUNT-1:0] rom_even_we;
    logic [ROM_COUNT-1:0] rom_odd_we;
    logic [BYTE_W-1:0]    even_wdata;
    logic [BYTE_W-1:0]    odd_wdata;
    logic                 port_we;
    logic [BYTE_W-1:0]    port_wdata;
    rd_ctl_t              ctl;
  } mem_req_t;

endpackage

@@ rtl/bmm_if.sv @@
interface bmm_req_if import bmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] address;
  logic [WORD_W-1:0] data_in;
  logic [SEL_W-1:0]  rom_select;

  modport source (output valid, output cmd, output address, output data_in,
                  output rom_select, input ready);
  modport sink (input valid, input cmd, input address, input data_in,
                input rom_select, output ready);
endinterface

interface bmm_rsp_if import bmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

@@ rtl/bmm_ram.sv @@
module bmm_ram import bmm_pkg::*; #(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = RAM_BANK_DEPTH
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/bmm_decode.sv @@
module bmm_decode import bmm_pkg::*; (
  input  logic [CMD_W-1:0]  cmd,
  input  logic [ADDR_W-1:0] address,
  input  logic [WORD_W-1:0] data_in,
  input  logic [SEL_W-1:0]  rom_select,
  input  logic [BYTE_W-1:0] port,
  output mem_req_t          mem_req
);

  function automatic src_t byte_src(input logic [ADDR_W-1:0] a,
                                    input logic [BYTE_W-1:0] p);
    src_t s;
    s = SRC_RAM;
    if (a[ADDR_W-1:BASIC_REGION_W] == BASIC_BASE[ADDR_W-1:BASIC_REGION_W]) begin
      if (p[PORT_BASIC_BIT]) s = SRC_BASIC;
    end else if (a[ADDR_W-1:KERNAL_REGION_W] ==
                 KERNAL_BASE[ADDR_W-1:KERNAL_REGION_W]) begin
      if (p[PORT_KERNAL_BIT]) s = SRC_KERNAL;
    end else if (a[ADDR_W-1:CHAR_REGION_W] == CHAR_BASE[ADDR_W-1:CHAR_REGION_W]) begin
      if (!p[PORT_CHAR_BIT]) s = SRC_CHAR;
    end
    return s;
  endfunction

  logic [ADDR_W-1:0] next_addr;
  logic [ADDR_W-1:0] even_addr;
  logic [ADDR_W-1:0] odd_addr;
  logic [BYTE_W-1:0] lo;
  logic [BYTE_W-1:0] hi;

  // The second byte of a word wraps from the top of the map to address zero.
  assign next_addr = address + 16'd1;
  assign even_addr = address[0] ? next_addr : address;
  assign odd_addr  = address[0] ? address : next_addr;
  assign lo        = data_in[BYTE_W-1:0];
  assign hi        = data_in[WORD_W-1:BYTE_W];

  always_comb begin
    mem_req              = '0;
    mem_req.ram_even_idx = even_addr[RAM_IDX_W:1];
    mem_req.ram_odd_idx  = odd_addr[RAM_IDX_W:1];
    mem_req.rom_even_idx = even_addr[ROM_IDX_W:1];
    mem_req.rom_odd_idx  = odd_addr[ROM_IDX_W:1];
    mem_req.even_wdata   = address[0] ? hi : lo;
    mem_req.odd_wdata    = address[0] ? lo : hi;
    mem_req.port_wdata   = lo;
    mem_req.ctl.src_even = byte_src(even_addr, port);
    mem_req.ctl.src_odd  = byte_src(odd_addr, port);
    mem_req.ctl.swap     = address[0];
    mem_req.ctl.kind     = RES_NONE;
    case (cmd)
      CMD_READ_BYTE: begin
        mem_req.ctl.kind = RES_BYTE;
      end
      CMD_READ_WORD: begin
        mem_req.ctl.kind = RES_WORD;
      end
      CMD_WRITE_BYTE: begin
        mem_req.ram_even_we = !address[0];
        mem_req.ram_odd_we  = address[0];
        mem_req.port_we     = (address == PORT_ADDR);
      end
      CMD_WRITE_WORD: begin
        mem_req.ram_even_we = 1'b1;
        mem_req.ram_odd_we  = 1'b1;
        if (address == PORT_ADDR) begin
          mem_req.port_we = 1'b1;
        end else if (next_addr == PORT_ADDR) begin
          mem_req.port_we    = 1'b1;
          mem_req.port_wdata = hi;
        end
      end
      CMD_LOAD_ROM: begin
        case (rom_select)
          ROM_BASIC: begin
            mem_req.rom_even_we[ROM_IDX_BASIC] = !address[0];
            mem_req.rom_odd_we[ROM_IDX_BASIC]  = address[0];
          end
          ROM_KERNAL: begin
            mem_req.rom_even_we[ROM_IDX_KERNAL] = !address[0];
            mem_req.rom_odd_we[ROM_IDX_KERNAL]  = address[0];
          end
          ROM_CHAR: begin
            mem_req.rom_even_we[ROM_IDX_CHAR] = !address[0];
            mem_req.rom_odd_we[ROM_IDX_CHAR]  = address[0];
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/banked_memory_map_decoder_core.sv @@
// Memory map of a home computer: 64 KiB of RAM with BASIC, KERNAL and
// character ROMs banked in by the I/O port byte at address 1. One command is
// accepted per clock cycle, byte or word alike, while the response side is
// not stalled and no reset sweep is running; its result passes through the
// registered memory read, then the result register. Every store is split
// into even and odd byte banks, each a single-port RAM, so the two bytes of a
// word are served in the same cycle. After reset the block writes the reset
// contents into all 32768 rows of the RAM banks, one row per cycle, and
// accepts no command until that pass is over.
`include "assert_macros.svh"

module banked_memory_map_decoder_core import bmm_pkg::*; (
  input logic         clk,
  input logic         rst,
  bmm_req_if.sink     req,
  bmm_rsp_if.source   rsp
);

  localparam logic [RAM_IDX_W-1:0] CLR_LAST = RAM_IDX_W'(RAM_BANK_DEPTH - 1);

  mem_req_t             mem_req;
  logic                 accept;
  logic                 s1_adv;
  logic                 s1_valid;
  rd_ctl_t              s1_ctl;
  logic                 out_valid;
  logic [WORD_W-1:0]    out_data;
  logic [BYTE_W-1:0]    port;
  logic                 clearing;
  logic [RAM_IDX_W-1:0] clr_idx;

  logic                 ram_en;
  logic                 ram_even_we;
  logic                 ram_odd_we;
  logic [RAM_IDX_W-1:0] ram_even_addr;
  logic [RAM_IDX_W-1:0] ram_odd_addr;
  logic [BYTE_W-1:0]    ram_even_wdata;
  logic [BYTE_W-1:0]    ram_odd_wdata;
  logic [BYTE_W-1:0]    clr_byte;

  logic [BYTE_W-1:0] ram_even_q, ram_odd_q;
  logic [BYTE_W-1:0] basic_even_q, basic_odd_q;
  logic [BYTE_W-1:0] kernal_even_q, kernal_odd_q;
  logic [BYTE_W-1:0] char_even_q, char_odd_q;
  logic [BYTE_W-1:0] even_byte, odd_byte, lo_byte, hi_byte;
  logic [WORD_W-1:0] result;

  bmm_decode u_decode (
    .cmd        (req.cmd),
    .address    (req.address),
    .data_in    (req.data_in),
    .rom_select (req.rom_select),
    .port       (port),
    .mem_req    (mem_req)
  );

  // The whole path advances only when the result register is free or drained.
  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !clearing && (!s1_valid || s1_adv);
  assign accept    = req.valid && req.ready;

  assign clr_byte       = (clr_idx == '0) ? RAM_LOW_RESET : '0;
  assign ram_en         = accept || clearing;
  assign ram_even_we    = clearing || mem_req.ram_even_we;
  assign ram_odd_we     = clearing || mem_req.ram_odd_we;
  assign ram_even_addr  = clearing ? clr_idx : mem_req.ram_even_idx;
  assign ram_odd_addr   = clearing ? clr_idx : mem_req.ram_odd_idx;
  assign ram_even_wdata = clearing ? clr_byte : mem_req.even_wdata;
  assign ram_odd_wdata  = clearing ? clr_byte : mem_req.odd_wdata;

  bmm_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_BANK_DEPTH)) u_ram_even (
    .clk (clk), .en (ram_en), .we (ram_even_we), .addr (ram_even_addr),
    .wdata (ram_even_wdata), .rdata (ram_even_q)
  );

  bmm_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_BANK_DEPTH)) u_ram_odd (
    .clk (clk), .en (ram_en), .we (ram_odd_we), .addr (ram_odd_addr),
    .wdata (ram_odd_wdata), .rdata (ram_odd_q)
  );

  bmm_ram #(.WIDTH(BYTE_W), .DEPTH(BASIC_BANK_DEPTH)) u_basic_even (
    .clk (clk), .en (accept), .we (mem_req.rom_even_we[ROM_IDX_BASIC]),
    .addr (mem_req.rom_even_idx), .wdata (mem_req.even_wdata), .rdata (basic_even_q)
  );

  bmm_ram #(.WIDTH(BYTE_W), .DEPTH(BASIC_BANK_DEPTH)) u_basic_odd (
    .clk (clk), .en (accept), .we (mem_req.rom_odd_we[ROM_IDX_BASIC]),
    .addr (mem_req.rom_odd_idx), .wdata (mem_req.odd_wdata), .rdata (basic_odd_q)
  );

  bmm_ram #(.WIDTH(BYTE_W), .DEPTH(KERNAL_BANK_DEPTH)) u_kernal_even (
    .clk (clk), .en (accept), .we (mem_req.rom_even_we[ROM_IDX_KERNAL]),
    .addr (mem_req.rom_even_idx), .wdata (mem_req.even_wdata),
    .rdata (kernal_even_q)
  );

  bmm_ram #(.WIDTH(BYTE_W), .DEPTH(KERNAL_BANK_DEPTH)) u_kernal_odd (
    .clk (clk), .en (accept), .we (mem_req.rom_odd_we[ROM_IDX_KERNAL]),
    .addr (mem_req.rom_odd_idx), .wdata (mem_req.odd_wdata), .rdata (kernal_odd_q)
  );

  bmm_ram #(.WIDTH(BYTE_W), .DEPTH(CHAR_BANK_DEPTH)) u_char_even (
    .clk (clk), .en (accept), .we (mem_req.rom_even_we[ROM_IDX_CHAR]),
    .addr (mem_req.rom_even_idx[CHAR_IDX_W-1:0]), .wdata (mem_req.even_wdata),
    .rdata (char_even_q)
  );

  bmm_ram #(.WIDTH(BYTE_W), .DEPTH(CHAR_BANK_DEPTH)) u_char_odd (
    .clk (clk), .en (accept), .we (mem_req.rom_odd_we[ROM_IDX_CHAR]),
    .addr (mem_req.rom_odd_idx[CHAR_IDX_W-1:0]), .wdata (mem_req.odd_wdata),
    .rdata (char_odd_q)
  );

  // Reset sweep over both RAM banks; row zero holds bytes 0 and 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + RAM_IDX_W'(1);
      if (clr_idx == CLR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // Copy of the I/O port byte, so bank selection needs no extra RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      port <= RAM_LOW_RESET;
    end else if (accept && mem_req.port_we) begin
      port <= mem_req.port_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl <= mem_req.ctl;
    end
  end

  always_comb begin
    case (s1_ctl.src_even)
      SRC_BASIC:  even_byte = basic_even_q;
      SRC_KERNAL: even_byte = kernal_even_q;
      SRC_CHAR:   even_byte = char_even_q;
      default:    even_byte = ram_even_q;
    endcase
    case (s1_ctl.src_odd)
      SRC_BASIC:  odd_byte = basic_odd_q;
      SRC_KERNAL: odd_byte = kernal_odd_q;
      SRC_CHAR:   odd_byte = char_odd_q;
      default:    odd_byte = ram_odd_q;
    endcase
    lo_byte = s1_ctl.swap ? odd_byte : even_byte;
    hi_byte = s1_ctl.swap ? even_byte : odd_byte;
    case (s1_ctl.kind)
      RES_BYTE: result = {{(WORD_W-BYTE_W){1'b0}}, lo_byte};
      RES_WORD: result = {hi_byte, lo_byte};
      default:  result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= result;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

  `ASSERT_ALWAYS(a_reset_starts_sweep, rst |=> (clearing && !rsp.valid), "reset must start the clearing sweep")
  `ASSERT_CLK(a_no_accept_in_sweep, clearing |-> !req.ready, "transfer accepted during clearing sweep")
  `ASSERT_CLK(a_sweep_complete, $fell(clearing) |-> ($past(clr_idx) == CLR_LAST), "clearing sweep ended early")
  `ASSERT_CLK(a_stage_holds, (s1_valid && rsp.valid && !rsp.ready) |=> s1_valid, "pending read lost while stalled")
  `ASSERT_CLK(a_port_tracks, (accept && req.cmd == CMD_WRITE_BYTE && req.address == PORT_ADDR) |=> (port == $past(req.data_in[BYTE_W-1:0])), "port copy missed a write")

endmodule

@@ sim/bmm_response_check.sv @@
module bmm_response_check import bmm_pkg::*; (
  input  logic clk,
  input  logic rst,
  bmm_req_if   req,
  bmm_rsp_if   rsp,
  output int   failures,
  output int   pending
);

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] read_data;
  } read_expect_t;

  logic [BYTE_W-1:0] ram_bytes  [RAM_BYTES];
  logic [BYTE_W-1:0] basic_rom  [BASIC_BYTES];
  logic [BYTE_W-1:0] kernal_rom [KERNAL_BYTES];
  logic [BYTE_W-1:0] char_rom   [CHAR_BYTES];

  read_expect_t expected_reads [$];

  // The banking bits are taken from the port byte as it stands before the command.
  function automatic logic [BYTE_W-1:0] visible_byte(input logic [ADDR_W-1:0] a);
    logic [BYTE_W-1:0] port;
    port = ram_bytes[PORT_ADDR];
    if (a[ADDR_W-1:BASIC_REGION_W] == BASIC_BASE[ADDR_W-1:BASIC_REGION_W] &&
        port[PORT_BASIC_BIT])
      return basic_rom[a[BASIC_REGION_W-1:0]];
    if (a[ADDR_W-1:KERNAL_REGION_W] == KERNAL_BASE[ADDR_W-1:KERNAL_REGION_W] &&
        port[PORT_KERNAL_BIT])
      return kernal_rom[a[KERNAL_REGION_W-1:0]];
    if (a[ADDR_W-1:CHAR_REGION_W] == CHAR_BASE[ADDR_W-1:CHAR_REGION_W] &&
        !port[PORT_CHAR_BIT])
      return char_rom[a[CHAR_REGION_W-1:0]];
    return ram_bytes[a];
  endfunction

  function automatic logic [WORD_W-1:0] bus_response(input logic [CMD_W-1:0]  cmd,
                                                     input logic [ADDR_W-1:0] address,
                                                     input logic [WORD_W-1:0] data_in,
                                                     input logic [SEL_W-1:0]  rom_select);
    logic [ADDR_W-1:0] next_addr;
    logic [WORD_W-1:0] result;
    next_addr = address + ADDR_W'(1);
    result = '0;
    case (cmd)
      CMD_READ_BYTE: begin
        result = {8'h00, visible_byte(address)};
      end
      CMD_WRITE_BYTE: begin
        ram_bytes[address] = data_in[7:0];
      end
      CMD_READ_WORD: begin
        result = {visible_byte(next_addr), visible_byte(address)};
      end
      CMD_WRITE_WORD: begin
        ram_bytes[address] = data_in[7:0];
        ram_bytes[next_addr] = data_in[15:8];
      end
      CMD_LOAD_ROM: begin
        case (rom_select)
          ROM_BASIC:  basic_rom[address[BASIC_REGION_W-1:0]] = data_in[7:0];
          ROM_KERNAL: kernal_rom[address[KERNAL_REGION_W-1:0]] = data_in[7:0];
          ROM_CHAR:   char_rom[address[CHAR_REGION_W-1:0]] = data_in[7:0];
          default: ;
        endcase
      end
      default: ;
    endcase
    return result;
  endfunction

  always @(posedge clk) begin
    read_expect_t e;
    if (rst) begin
      for (int i = 0; i < RAM_BYTES; i++) ram_bytes[i] = '0;
      for (int i = 0; i < BASIC_BYTES; i++) basic_rom[i] = '0;
      for (int i = 0; i < KERNAL_BYTES; i++) kernal_rom[i] = '0;
      for (int i = 0; i < CHAR_BYTES; i++) char_rom[i] = '0;
      ram_bytes[0] = RAM_LOW_RESET;
      ram_bytes[PORT_ADDR] = RAM_LOW_RESET;
      expected_reads.delete();
      failures = 0;
    end else begin
      if (req.valid && req.ready) begin
        e.cmd = req.cmd;
        e.address = req.address;
        e.read_data = bus_response(req.cmd, req.address, req.data_in, req.rom_select);
        expected_reads.push_back(e);
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_reads.size() == 0) begin
          failures = failures + 1;
          $display("%0t: read_data expected none, got %h", $time, rsp.read_data);
        end else begin
          e = expected_reads.pop_front();
          if (rsp.read_data !== e.read_data) begin
            failures = failures + 1;
            $display("%0t: read_data for cmd %0d at %h: expected %h, got %h",
                     $time, e.cmd, e.address, e.read_data, rsp.read_data);
          end
        end
      end
    end
    pending = expected_reads.size();
  end

endmodule

@@ sim/tb_banked_memory_map_decoder_core.sv @@
module tb_banked_memory_map_decoder_core;
  import bmm_pkg::*;

  localparam int STALL_LIMIT     = 100000;
  localparam int HOLD_CYCLES     = 250;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int SETTLE_CYCLES   = 20;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [SEL_W-1:0] ROM_UNUSED    = 2'd3;

  logic clk;
  logic rst;
  int   failures;
  int   pending;
  int   quiet_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_requests = 0;
  int   hold_served = 0;

  // What the stimulus knows of the map, so that no read lands on a ROM byte never loaded.
  logic [BYTE_W-1:0] port_shadow = RAM_LOW_RESET;
  bit basic_loaded  [BASIC_BYTES];
  bit kernal_loaded [KERNAL_BYTES];
  bit char_loaded   [CHAR_BYTES];

  bmm_req_if req ();
  bmm_rsp_if rsp ();

  banked_memory_map_decoder_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  bmm_response_check scoreboard (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .failures (failures),
    .pending  (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_served + 1;
        repeat (HOLD_CYCLES) begin
          rsp.ready <= 1'b0;
          @(negedge clk);
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic bit hits_blank_rom(input  logic [ADDR_W-1:0] a,
                                        output logic [SEL_W-1:0]  sel,
                                        output logic [ADDR_W-1:0] off);
    sel = ROM_UNUSED;
    off = '0;
    if (a[ADDR_W-1:BASIC_REGION_W] == BASIC_BASE[ADDR_W-1:BASIC_REGION_W]) begin
      if (port_shadow[PORT_BASIC_BIT] && !basic_loaded[a[BASIC_REGION_W-1:0]]) begin
        sel = ROM_BASIC;
        off = a - BASIC_BASE;
      end
    end else if (a[ADDR_W-1:KERNAL_REGION_W] == KERNAL_BASE[ADDR_W-1:KERNAL_REGION_W]) begin
      if (port_shadow[PORT_KERNAL_BIT] && !kernal_loaded[a[KERNAL_REGION_W-1:0]]) begin
        sel = ROM_KERNAL;
        off = a - KERNAL_BASE;
      end
    end else if (a[ADDR_W-1:CHAR_REGION_W] == CHAR_BASE[ADDR_W-1:CHAR_REGION_W]) begin
      if (!port_shadow[PORT_CHAR_BIT] && !char_loaded[a[CHAR_REGION_W-1:0]]) begin
        sel = ROM_CHAR;
        off = a - CHAR_BASE;
      end
    end
    return sel != ROM_UNUSED;
  endfunction

  // The load offset wraps, so the bits above the ROM size are left random.
  function automatic logic [ADDR_W-1:0] rom_address(input logic [SEL_W-1:0]  sel,
                                                    input logic [ADDR_W-1:0] off);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'($urandom_range(65535));
    case (sel)
      ROM_BASIC:  a[BASIC_REGION_W-1:0] = off[BASIC_REGION_W-1:0];
      ROM_KERNAL: a[KERNAL_REGION_W-1:0] = off[KERNAL_REGION_W-1:0];
      ROM_CHAR:   a[CHAR_REGION_W-1:0] = off[CHAR_REGION_W-1:0];
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] rom_offset(input logic [SEL_W-1:0] sel);
    int span;
    int r;
    span = (sel == ROM_CHAR) ? CHAR_BYTES : (sel == ROM_KERNAL) ? KERNAL_BYTES : BASIC_BYTES;
    r = $urandom_range(99);
    if (r < 45) return ADDR_W'($urandom_range(63));
    if (r < 90) return ADDR_W'(span - 64 + $urandom_range(63));
    return ADDR_W'($urandom_range(span - 1));
  endfunction

  // Reads and writes cluster at the region edges and in low RAM, where the port lives.
  function automatic logic [ADDR_W-1:0] hot_address();
    int r;
    logic [ADDR_W-1:0] base;
    r = $urandom_range(99);
    if (r < 20) return ADDR_W'($urandom_range(63));
    if (r >= 55) return ADDR_W'($urandom_range(65535));
    case ($urandom_range(5))
      0: base = BASIC_BASE;
      1: base = BASIC_BASE + ADDR_W'(BASIC_BYTES - 64);
      2: base = KERNAL_BASE;
      3: base = KERNAL_BASE + ADDR_W'(KERNAL_BYTES - 64);
      4: base = CHAR_BASE;
      default: base = CHAR_BASE + ADDR_W'(CHAR_BYTES - 64);
    endcase
    return base + ADDR_W'($urandom_range(63));
  endfunction

  task automatic issue_command(input logic [CMD_W-1:0]  cmd,
                               input logic [ADDR_W-1:0] address,
                               input logic [WORD_W-1:0] data_in,
                               input logic [SEL_W-1:0]  rom_select);
    logic [SEL_W-1:0]  blank_sel;
    logic [ADDR_W-1:0] blank_off;
    logic [ADDR_W-1:0] next_addr;
    bit                blank;
    next_addr = address + ADDR_W'(1);
    blank = 1'b0;
    if (cmd == CMD_READ_BYTE || cmd == CMD_READ_WORD) begin
      blank = hits_blank_rom(address, blank_sel, blank_off);
      if (!blank && cmd == CMD_READ_WORD) blank = hits_blank_rom(next_addr, blank_sel, blank_off);
    end
    // A read that would see an unloaded ROM byte becomes the load of that byte.
    if (blank) begin
      cmd = CMD_LOAD_ROM;
      rom_select = blank_sel;
      address = rom_address(blank_sel, blank_off);
    end
    case (cmd)
      CMD_WRITE_BYTE: begin
        if (address == PORT_ADDR) port_shadow = data_in[7:0];
      end
      CMD_WRITE_WORD: begin
        if (address == PORT_ADDR) port_shadow = data_in[7:0];
        else if (next_addr == PORT_ADDR) port_shadow = data_in[15:8];
      end
      CMD_LOAD_ROM: begin
        case (rom_select)
          ROM_BASIC:  basic_loaded[address[BASIC_REGION_W-1:0]] = 1'b1;
          ROM_KERNAL: kernal_loaded[address[KERNAL_REGION_W-1:0]] = 1'b1;
          ROM_CHAR:   char_loaded[address[CHAR_REGION_W-1:0]] = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.address <= address;
    req.data_in <= data_in;
    req.rom_select <= rom_select;
    do @(posedge clk); while (req.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic random_command();
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] data_in;
    logic [SEL_W-1:0]  rom_select;
    int                r;
    r = $urandom_range(99);
    data_in = WORD_W'($urandom_range(65535));
    rom_select = SEL_W'($urandom_range(3));
    address = hot_address();
    if (r < 28) begin
      cmd = CMD_READ_BYTE;
    end else if (r < 52) begin
      cmd = CMD_READ_WORD;
    end else if (r < 64) begin
      cmd = CMD_WRITE_BYTE;
      if ($urandom_range(99) < 20) address = PORT_ADDR;
    end else if (r < 74) begin
      cmd = CMD_WRITE_WORD;
      case ($urandom_range(9))
        0: address = '0;
        1: address = PORT_ADDR;
        2: address = '1;
        default: ;
      endcase
    end else if (r < 95) begin
      cmd = CMD_LOAD_ROM;
      if ($urandom_range(99) < 5) begin
        rom_select = ROM_UNUSED;
        address = ADDR_W'($urandom_range(65535));
      end else begin
        rom_select = SEL_W'($urandom_range(2));
        address = rom_address(rom_select, rom_offset(rom_select));
      end
    end else begin
      cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    end
    issue_command(cmd, address, data_in, rom_select);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    req.valid <= 1'b0;
    req.cmd <= CMD_READ_BYTE;
    req.address <= '0;
    req.data_in <= '0;
    req.rom_select <= ROM_BASIC;
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset contents, ROM loads at both ends with wrapping offsets, banking changes, word wrap and unused commands.
    issue_command(CMD_READ_BYTE, PORT_ADDR, 16'h0000, ROM_BASIC);
    issue_command(CMD_READ_WORD, 16'h0000, 16'hFFFF, ROM_CHAR);
    issue_command(CMD_LOAD_ROM, 16'h0000, 16'hFFA5, ROM_BASIC);
    issue_command(CMD_LOAD_ROM, 16'hFFFF, 16'h005A, ROM_BASIC);
    issue_command(CMD_LOAD_ROM, 16'hE000, 16'h12C3, ROM_KERNAL);
    issue_command(CMD_LOAD_ROM, 16'h1FFF, 16'hFF3C, ROM_KERNAL);
    issue_command(CMD_LOAD_ROM, 16'h0000, 16'h0081, ROM_CHAR);
    issue_command(CMD_LOAD_ROM, 16'hFFFF, 16'hFF7E, ROM_CHAR);
    issue_command(CMD_LOAD_ROM, 16'h1234, 16'hFFFF, ROM_UNUSED);
    issue_command(CMD_READ_BYTE, 16'hA000, 16'h0000, ROM_BASIC);
    issue_command(CMD_READ_BYTE, 16'hBFFF, 16'h0000, ROM_BASIC);
    issue_command(CMD_READ_WORD, 16'hFFFF, 16'h0000, ROM_BASIC);
    issue_command(CMD_READ_BYTE, 16'hE000, 16'h0000, ROM_BASIC);
    issue_command(CMD_WRITE_BYTE, PORT_ADDR, 16'hFF00, ROM_BASIC);
    issue_command(CMD_READ_BYTE, 16'hD000, 16'h0000, ROM_BASIC);
    issue_command(CMD_READ_BYTE, 16'hDFFF, 16'h0000, ROM_BASIC);
    issue_command(CMD_READ_BYTE, 16'hA000, 16'h0000, ROM_BASIC);
    issue_command(CMD_WRITE_WORD, 16'hFFFF, 16'hABCD, ROM_BASIC);
    issue_command(CMD_READ_WORD, 16'hFFFF, 16'h0000, ROM_BASIC);
    issue_command(CMD_WRITE_WORD, 16'h0000, 16'h0605, ROM_BASIC);
    issue_command(CMD_READ_WORD, 16'hFFFF, 16'h0000, ROM_BASIC);
    issue_command(CMD_UNUSED_LO, 16'hFFFF, 16'hFFFF, ROM_UNUSED);
    issue_command(CMD_UNUSED_HI, 16'h0001, 16'h0000, ROM_BASIC);
    issue_command(CMD_WRITE_WORD, PORT_ADDR, 16'hFF07, ROM_BASIC);
    issue_command(CMD_READ_WORD, 16'h0000, 16'h0000, ROM_BASIC);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 73 : 0;
      recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 18 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ((phase == 0 && i == 150) || (phase == 2 && i == 100))
          hold_requests = hold_requests + 1;
        if (phase == 1 && i == 200) drain();
        random_command();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ banked_memory_map_decoder_core.f @@
+incdir+rtl
rtl/bmm_pkg.sv
rtl/bmm_if.sv
rtl/bmm_ram.sv
rtl/bmm_decode.sv
rtl/banked_memory_map_decoder_core.sv
sim/bmm_response_check.sv
sim/tb_banked_memory_map_decoder_core.sv
